// ----- hdl/bol_pkg.sv -----
package bol_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int POS_W  = 8;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_READ       = 2'd2,
    MODE_DELETE     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [DATA_W-1:0]  item_value;
    logic        [POS_W-1:0]   position;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  read_value;
    status_t                   status;
  } rsp_t;

  typedef struct packed {
    logic              busy;
    logic [CNT_W-1:0]  count;
  } stat_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [DATA_W-1:0]    wdata;
    logic [ADDR_W-1:0]    raddr;
  } mem_req_t;

endpackage

// ----- hdl/bol_mem.sv -----
module bol_mem (
  input  logic                        clk,
  input  bol_pkg::mem_req_t           mreq,
  output logic [bol_pkg::DATA_W-1:0]  rdata
);

  logic [bol_pkg::DATA_W-1:0] mem [bol_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mreq.waddr] <= mreq.wdata;
    end
    rdata <= mem[mreq.raddr];
  end

endmodule

// ----- hdl/bol_ctrl.sv -----
module bol_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  bol_pkg::req_t               req,
  input  logic                        rsp_stall,
  output logic                        rsp_valid,
  output bol_pkg::rsp_t               rsp,
  output bol_pkg::stat_t              stat,
  output bol_pkg::mem_req_t           mreq,
  input  logic [bol_pkg::DATA_W-1:0]  mem_rdata
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_SHIFT = 7'b0000100,
    S_FRONT = 7'b0001000,
    S_READ  = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t                        state, state_next;
  bol_pkg::req_t                 op, op_next;
  bol_pkg::rsp_t                 res, res_next;
  logic [bol_pkg::CNT_W-1:0]     count, count_next;
  logic [bol_pkg::ADDR_W-1:0]    ridx, ridx_next;
  logic                          found, found_next;
  logic                          match;
  logic                          last;
  logic                          load;

  // shared compare unit
  assign match = (mem_rdata == op.item_value);
  assign last  = (bol_pkg::CNT_W'(ridx) == count - bol_pkg::CNT_W'(1));
  assign load  = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  always_comb begin
    state_next  = state;
    op_next     = op;
    res_next    = res;
    count_next  = count;
    ridx_next   = ridx;
    found_next  = found;
    mreq.we     = 1'b0;
    mreq.waddr  = '0;
    mreq.wdata  = op.item_value;
    mreq.raddr  = ridx;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_next    = req;
          state_next = S_START;
        end
      end
      S_START: begin
        res_next.read_value = '0;
        res_next.status     = bol_pkg::ST_OK;
        unique case (op.mode)
          bol_pkg::MODE_PUSH_FRONT, bol_pkg::MODE_PUSH_BACK: begin
            if (count == bol_pkg::CNT_W'(bol_pkg::DEPTH)) begin
              res_next.status = bol_pkg::ST_FULL;
              state_next      = S_DONE;
            end else if (op.mode == bol_pkg::MODE_PUSH_BACK || count == '0) begin
              mreq.we    = 1'b1;
              mreq.waddr = count[bol_pkg::ADDR_W-1:0];
              count_next = count + bol_pkg::CNT_W'(1);
              state_next = S_DONE;
            end else begin
              mreq.raddr = bol_pkg::ADDR_W'(count - bol_pkg::CNT_W'(1));
              ridx_next  = bol_pkg::ADDR_W'(count - bol_pkg::CNT_W'(1));
              state_next = S_SHIFT;
            end
          end
          bol_pkg::MODE_READ: begin
            if (bol_pkg::CMP_W'(op.position) < bol_pkg::CMP_W'(count)) begin
              mreq.raddr = op.position[bol_pkg::ADDR_W-1:0];
              state_next = S_READ;
            end else begin
              res_next.read_value = '1;
              res_next.status     = bol_pkg::ST_RANGE;
              state_next          = S_DONE;
            end
          end
          bol_pkg::MODE_DELETE: begin
            if (count == '0) begin
              res_next.status = bol_pkg::ST_NOTFOUND;
              state_next      = S_DONE;
            end else begin
              mreq.raddr = '0;
              ridx_next  = '0;
              found_next = 1'b0;
              state_next = S_SCAN;
            end
          end
        endcase
      end
      S_SHIFT: begin
        mreq.we    = 1'b1;
        mreq.waddr = ridx + bol_pkg::ADDR_W'(1);
        mreq.wdata = mem_rdata;
        if (ridx == '0) begin
          state_next = S_FRONT;
        end else begin
          mreq.raddr = ridx - bol_pkg::ADDR_W'(1);
          ridx_next  = ridx - bol_pkg::ADDR_W'(1);
        end
      end
      S_FRONT: begin
        mreq.we    = 1'b1;
        mreq.waddr = '0;
        count_next = count + bol_pkg::CNT_W'(1);
        state_next = S_DONE;
      end
      S_READ: begin
        res_next.read_value = mem_rdata;
        state_next          = S_DONE;
      end
      S_SCAN: begin
        // after the hit, each element read moves down one slot
        if (found) begin
          mreq.we    = 1'b1;
          mreq.waddr = ridx - bol_pkg::ADDR_W'(1);
          mreq.wdata = mem_rdata;
        end else if (match) begin
          found_next = 1'b1;
        end
        if (last) begin
          if (found || match) begin
            count_next = count - bol_pkg::CNT_W'(1);
          end else begin
            res_next.status = bol_pkg::ST_NOTFOUND;
          end
          state_next = S_DONE;
        end else begin
          mreq.raddr = ridx + bol_pkg::ADDR_W'(1);
          ridx_next  = ridx + bol_pkg::ADDR_W'(1);
        end
      end
      S_DONE: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op    <= op_next;
    res   <= res_next;
    ridx  <= ridx_next;
    found <= found_next;
    if (load) begin
      rsp <= res;
    end
  end

  assign stat.busy  = (state != S_IDLE);
  assign stat.count = count;

endmodule

// ----- hdl/bounded_ordered_list.sv -----
// Ordered list of up to DEPTH signed 32-bit values in a single-port-write,
// registered-read memory. One transaction is taken at a time; req_stall is
// high from acceptance until the result is loaded into the output register,
// which holds it while rsp_stall is high. A push front to a non-empty
// list moves every stored entry up one slot (to an empty list it runs as
// a push back) and a delete reads every stored entry, because the single
// memory port walks the stored entries one per cycle with one shared
// compare unit. Every transaction returns exactly one result.
module bounded_ordered_list (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  bol_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output bol_pkg::rsp_t   rsp
);

  bol_pkg::stat_t                stat;
  bol_pkg::mem_req_t             mreq;
  logic [bol_pkg::DATA_W-1:0]    mem_rdata;

  bol_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .stat      (stat),
    .mreq      (mreq),
    .mem_rdata (mem_rdata)
  );

  bol_mem u_mem (
    .clk   (clk),
    .mreq  (mreq),
    .rdata (mem_rdata)
  );

  assign req_stall = stat.busy;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= bol_pkg::CNT_W'(bol_pkg::DEPTH))
    else $error("list count exceeds depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("not busy after accepting a transaction");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (stat.count == $past(stat.count) ||
                     stat.count == $past(stat.count) + bol_pkg::CNT_W'(1) ||
                     stat.count + bol_pkg::CNT_W'(1) == $past(stat.count)))
    else $error("count changed by more than one");

  a_idle_count_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(stat.busy) |-> stat.count == $past(stat.count))
    else $error("count changed while idle");

endmodule

// ----- tb/sv/bounded_ordered_list_tb.sv -----
module bounded_ordered_list_tb;

  localparam int LIMIT    = 200000;
  localparam int SHOW_MAX = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_stall = 1'b0;
  logic req_stall;
  logic rsp_valid;
  bol_pkg::req_t req = '0;
  bol_pkg::rsp_t rsp;

  bounded_ordered_list DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  // shadow copy of the list contents, front first
  logic signed [bol_pkg::DATA_W-1:0] list_mem [bol_pkg::DEPTH];
  int list_len = 0;
  bol_pkg::rsp_t expected_q[$];

  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  bit send_gaps = 1'b1;
  bit rsp_gaps = 1'b1;
  int hold_cycles = 0;
  int stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bol_pkg::rsp_t list_apply(bol_pkg::req_t r);
    bol_pkg::rsp_t res;
    int hit;
    res.read_value = '0;
    res.status = bol_pkg::ST_OK;
    hit = -1;
    case (r.mode)
      bol_pkg::MODE_PUSH_FRONT: begin
        if (list_len >= bol_pkg::DEPTH) begin
          res.status = bol_pkg::ST_FULL;
        end else begin
          for (int i = list_len; i > 0; i--) list_mem[i] = list_mem[i-1];
          list_mem[0] = r.item_value;
          list_len++;
        end
      end
      bol_pkg::MODE_PUSH_BACK: begin
        if (list_len >= bol_pkg::DEPTH) begin
          res.status = bol_pkg::ST_FULL;
        end else begin
          list_mem[list_len] = r.item_value;
          list_len++;
        end
      end
      bol_pkg::MODE_READ: begin
        if (int'(r.position) < list_len) begin
          res.read_value = list_mem[r.position];
        end else begin
          res.read_value = -1;
          res.status = bol_pkg::ST_RANGE;
        end
      end
      default: begin
        for (int i = 0; i < list_len && hit < 0; i++)
          if (list_mem[i] == r.item_value) hit = i;
        if (hit < 0) begin
          res.status = bol_pkg::ST_NOTFOUND;
        end else begin
          for (int i = hit; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
    endcase
    return res;
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors <= SHOW_MAX) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // results are sampled on the falling edge before the edge that accepts them
  always @(negedge clk) begin
    bol_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected transaction: read_value=%0d status=%0d",
                         rsp.read_value, rsp.status));
      end else begin
        want = expected_q.pop_front();
        if (rsp.read_value !== want.read_value)
          report($sformatf("read_value: expected %0d, got %0d",
                           want.read_value, rsp.read_value));
        if (rsp.status !== want.status)
          report($sformatf("status: expected %0d, got %0d", want.status, rsp.status));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        rsp_stall <= 1'b1;
        hold_cycles--;
      end else if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else if (!quiet && rsp_gaps && $urandom_range(0, 7) == 0) begin
        rsp_stall <= 1'b1;
        stall_left = $urandom_range(0, 14);
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("bounded_ordered_list_tb NOT OK");
    $finish;
  end

  // called at a rising edge; returns at the edge that accepts the transaction
  task automatic send(bol_pkg::mode_t m, logic signed [bol_pkg::DATA_W-1:0] v,
                      logic [bol_pkg::POS_W-1:0] p);
    bol_pkg::req_t r;
    int gap;
    r.mode = m;
    r.item_value = v;
    r.position = p;
    if (!quiet && send_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(negedge clk);
    while (req_stall) @(negedge clk);
    expected_q.push_back(list_apply(r));
    @(posedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [bol_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return -1;
          default: return 0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_list();
    send(bol_pkg::MODE_READ, 0, 8'd0);
    send(bol_pkg::MODE_READ, 32'sh5A5A_5A5A, 8'hFF);
    send(bol_pkg::MODE_DELETE, 0, 8'd0);
    send(bol_pkg::MODE_DELETE, -1, 8'hAA);
  endtask

  task automatic test_extremes();
    send(bol_pkg::MODE_PUSH_BACK, 32'sh8000_0000, 8'h55);
    send(bol_pkg::MODE_PUSH_BACK, 32'sh7FFF_FFFF, 8'd0);
    send(bol_pkg::MODE_PUSH_FRONT, -1, 8'd0);
    send(bol_pkg::MODE_PUSH_FRONT, 0, 8'hFF);
    for (int i = 0; i <= 4; i++)
      send(bol_pkg::MODE_READ, $urandom, i[bol_pkg::POS_W-1:0]);
    send(bol_pkg::MODE_READ, 0, 8'hFF);
    send(bol_pkg::MODE_DELETE, 32'sh8000_0000, 8'd0);
    send(bol_pkg::MODE_READ, 0, 8'd2);
  endtask

  task automatic test_duplicates();
    send(bol_pkg::MODE_PUSH_BACK, 42, 8'd0);
    send(bol_pkg::MODE_PUSH_FRONT, 9, 8'd0);
    send(bol_pkg::MODE_PUSH_BACK, 42, 8'd0);
    send(bol_pkg::MODE_DELETE, 42, 8'd0);
    for (int i = 0; i < list_len; i++)
      send(bol_pkg::MODE_READ, 0, i[bol_pkg::POS_W-1:0]);
    send(bol_pkg::MODE_DELETE, 42, 8'd0);
    send(bol_pkg::MODE_DELETE, 42, 8'd0);
  endtask

  task automatic test_full_list();
    bol_pkg::mode_t m;
    while (list_len < bol_pkg::DEPTH) begin
      m = $urandom_range(0, 1) ? bol_pkg::MODE_PUSH_FRONT : bol_pkg::MODE_PUSH_BACK;
      send(m, pick_value(), bol_pkg::POS_W'($urandom));
    end
    send(bol_pkg::MODE_PUSH_FRONT, 1, 8'd0);
    send(bol_pkg::MODE_PUSH_BACK, 2, 8'd0);
    send(bol_pkg::MODE_READ, 0, bol_pkg::POS_W'(bol_pkg::DEPTH - 1));
    send(bol_pkg::MODE_READ, 0, bol_pkg::POS_W'(bol_pkg::DEPTH));
    send(bol_pkg::MODE_DELETE, list_mem[bol_pkg::DEPTH-1], 8'd0);
    while (list_len > 0)
      send(bol_pkg::MODE_DELETE, list_mem[0], bol_pkg::POS_W'($urandom));
  endtask

  task automatic random_item(bit filling);
    int roll;
    logic signed [bol_pkg::DATA_W-1:0] v;
    logic [bol_pkg::POS_W-1:0] p;
    roll = $urandom_range(0, 99);
    p = bol_pkg::POS_W'($urandom);
    if (roll < (filling ? 60 : 20)) begin
      send($urandom_range(0, 1) ? bol_pkg::MODE_PUSH_FRONT : bol_pkg::MODE_PUSH_BACK,
           pick_value(), p);
    end else if (roll < (filling ? 85 : 45)) begin
      if ($urandom_range(0, 4) != 0) p = bol_pkg::POS_W'($urandom_range(0, list_len));
      send(bol_pkg::MODE_READ, $urandom, p);
    end else begin
      if (list_len > 0 && $urandom_range(0, 3) != 0)
        v = list_mem[$urandom_range(0, list_len - 1)];
      else
        v = pick_value();
      send(bol_pkg::MODE_DELETE, v, p);
    end
  endtask

  task automatic test_backpressure();
    send_gaps = 1'b0;
    hold_cycles = 400;
    for (int i = 0; i < 12; i++) random_item(1'b1);
    wait_drained();
    send_gaps = 1'b1;
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) begin
      if (k % 50 == 0) begin
        send_gaps = $urandom_range(0, 2) != 0;
        rsp_gaps = $urandom_range(0, 2) != 0;
      end
      random_item(((k / 40) % 2) == 0);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_extremes();
    test_duplicates();
    test_full_list();
    test_backpressure();
    test_random(320);
    quiet = 1'b1;
    test_random(60);
    wait_drained();
    repeat (bol_pkg::DEPTH + 10) @(posedge clk);
    if (errors == 0)
      $display("bounded_ordered_list_tb OK");
    else
      $display("bounded_ordered_list_tb NOT OK");
    $finish;
  end

endmodule
